FILE: hdl/prq_pkg.sv
package prq_pkg;

    localparam int NUM_TASKS   = 16;
    localparam int PRIO_LEVELS = 8;
    localparam int ID_W        = $clog2(NUM_TASKS);
    localparam int PRIO_W      = $clog2(PRIO_LEVELS);
    localparam int CNT_W       = $clog2(NUM_TASKS + 1);

    localparam logic [2:0] CMD_ENQ = 3'd0;
    localparam logic [2:0] CMD_DEQ = 3'd1;
    localparam logic [2:0] CMD_REM = 3'd2;
    localparam logic [2:0] CMD_SET = 3'd3;
    localparam logic [2:0] CMD_GET = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_QUEUED = 2'd2;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] task_id;
        logic [2:0] new_priority;
    } cmd_t;

    typedef struct packed {
        logic [3:0] out_task;
        logic [2:0] out_priority;
        logic [1:0] status;
        logic [4:0] queue_count;
    } rsp_t;

endpackage

FILE: hdl/prq_if.sv
interface prq_cmd_if;
    import prq_pkg::*;
    logic valid;
    logic ready;
    cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface prq_rsp_if;
    import prq_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/prq_ram.sv
module prq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/priority_ready_queue_core.sv
// Priority ready queue for a task scheduler.
// Channels: cmd (sink) takes one transaction of cmd, task_id and new_priority;
// rsp (source) returns one transaction of out_task, out_priority, status and
// queue_count for every command.
// One command is worked at a time. The list links live in a RAM with a
// registered read; for each visited entry the walk issues a read and then
// uses the data. A new command is accepted only in the idle state with no
// result waiting, so it is not taken before the last result is handed over.
// Priorities and queued marks sit in flip-flops set by reset.
// Reset: queue empty, all priorities least urgent; cmd ready follows reset.
// When the receiver stalls, the result is held in the output register and
// the next command is not accepted until it is taken.
module priority_ready_queue_core (
    input  logic clk,
    input  logic rst_n,
    prq_cmd_if.sink   cmd,
    prq_rsp_if.source rsp
);
    import prq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_UL_RD, S_UL_CHK, S_UL_FIX_RD, S_UL_FIX,
        S_IN_START, S_IN_RD, S_IN_CHK, S_IN_LINK, S_IN_LINK2, S_DONE
    } state_t;

    state_t state_reg;
    cmd_t   cur_reg;
    logic [PRIO_W-1:0] prio_reg [NUM_TASKS];
    logic [NUM_TASKS-1:0] mark_reg;
    logic [ID_W-1:0] head_reg, tail_reg, prev_reg, otask_reg, id_reg;
    logic [CNT_W-1:0] count_reg, iter_reg;
    logic [1:0] status_reg;
    logic reins_reg;
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    logic we;
    logic [ID_W-1:0] waddr, raddr, rdata;
    logic [ID_W-1:0] wdata;

    prq_ram #(.WIDTH(ID_W), .DEPTH(NUM_TASKS)) u_link (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic id_ok;
    logic [PRIO_W-1:0] np_sat;
    assign id_ok = ({1'b0, cur_reg.task_id} < 5'(NUM_TASKS));
    assign np_sat = ({1'b0, cur_reg.new_priority} > 4'(PRIO_LEVELS - 1)) ?
                    PRIO_W'(PRIO_LEVELS - 1) : PRIO_W'(cur_reg.new_priority);

    assign cmd.ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    // link RAM read and write controls
    always_comb
    begin
        we    = 1'b0;
        waddr = prev_reg;
        wdata = id_reg;
        raddr = prev_reg;
        case (state_reg)
            S_UL_FIX_RD: raddr = id_reg;
            S_UL_FIX:
            begin
                we    = 1'b1;
                waddr = prev_reg;
                wdata = rdata;
            end
            S_IN_START:
            begin
                we    = (count_reg != '0) && (prio_reg[head_reg] > prio_reg[id_reg]);
                waddr = id_reg;
                wdata = head_reg;
            end
            S_IN_LINK:
            begin
                we    = 1'b1;
                waddr = (prev_reg == tail_reg) ? prev_reg : id_reg;
                wdata = (prev_reg == tail_reg) ? id_reg : rdata;
            end
            S_IN_LINK2:
            begin
                we    = 1'b1;
                waddr = prev_reg;
                wdata = id_reg;
            end
            default: ;
        endcase
    end

    // command sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mark_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                prio_reg[i] <= PRIO_W'(PRIO_LEVELS - 1);
            end
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid && cmd.ready)
                    begin
                        cur_reg   <= cmd.data;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    otask_reg  <= cur_reg.task_id;
                    status_reg <= ST_OK;
                    id_reg     <= cur_reg.task_id;
                    reins_reg  <= 1'b0;
                    state_reg  <= S_DONE;
                    if (cur_reg.cmd == CMD_DEQ)
                    begin
                        if (count_reg == '0)
                        begin
                            status_reg <= ST_MISS;
                        end
                        else
                        begin
                            otask_reg <= head_reg;
                            id_reg    <= head_reg;
                            state_reg <= S_UL_RD;
                        end
                    end
                    else if (cur_reg.cmd inside {CMD_ENQ, CMD_REM, CMD_SET, CMD_GET} && !id_ok)
                    begin
                        status_reg <= ST_MISS;
                    end
                    else if (cur_reg.cmd == CMD_ENQ)
                    begin
                        if (mark_reg[cur_reg.task_id])
                            status_reg <= ST_QUEUED;
                        else
                            state_reg <= S_IN_START;
                    end
                    else if (cur_reg.cmd == CMD_REM)
                    begin
                        if (!mark_reg[cur_reg.task_id])
                            status_reg <= ST_MISS;
                        else
                            state_reg <= S_UL_RD;
                    end
                    else if (cur_reg.cmd == CMD_SET)
                    begin
                        if (mark_reg[cur_reg.task_id])
                        begin
                            reins_reg <= 1'b1;
                            state_reg <= S_UL_RD;
                        end
                        else
                        begin
                            prio_reg[cur_reg.task_id] <= np_sat;
                        end
                    end
                    prev_reg <= head_reg;
                    iter_reg <= CNT_W'(1);
                end
                // unlink: head case or start walking
                S_UL_RD:
                begin
                    if (head_reg == id_reg)
                    begin
                        if (count_reg > CNT_W'(1))
                            state_reg <= S_UL_CHK;
                        else
                        begin
                            count_reg        <= count_reg - 1'b1;
                            mark_reg[id_reg] <= 1'b0;
                            state_reg        <= reins_reg ? S_IN_START : S_DONE;
                            if (reins_reg) prio_reg[id_reg] <= np_sat;
                        end
                    end
                    else if (iter_reg >= count_reg)
                    begin
                        state_reg <= reins_reg ? S_IN_START : S_DONE;
                        if (reins_reg) prio_reg[id_reg] <= np_sat;
                    end
                    else
                    begin
                        state_reg <= S_UL_CHK;
                    end
                end
                S_UL_CHK:
                begin
                    if (head_reg == id_reg)
                    begin
                        head_reg         <= rdata;
                        count_reg        <= count_reg - 1'b1;
                        mark_reg[id_reg] <= 1'b0;
                        state_reg        <= reins_reg ? S_IN_START : S_DONE;
                        if (reins_reg) prio_reg[id_reg] <= np_sat;
                    end
                    else if (rdata == id_reg)
                    begin
                        if (tail_reg == id_reg)
                        begin
                            tail_reg         <= prev_reg;
                            count_reg        <= count_reg - 1'b1;
                            mark_reg[id_reg] <= 1'b0;
                            state_reg        <= reins_reg ? S_IN_START : S_DONE;
                            if (reins_reg) prio_reg[id_reg] <= np_sat;
                        end
                        else
                        begin
                            state_reg <= S_UL_FIX_RD;
                        end
                    end
                    else
                    begin
                        prev_reg  <= rdata;
                        iter_reg  <= iter_reg + 1'b1;
                        state_reg <= S_UL_RD;
                    end
                end
                S_UL_FIX_RD: state_reg <= S_UL_FIX;
                S_UL_FIX:
                begin
                    count_reg        <= count_reg - 1'b1;
                    mark_reg[id_reg] <= 1'b0;
                    state_reg        <= reins_reg ? S_IN_START : S_DONE;
                    if (reins_reg) prio_reg[id_reg] <= np_sat;
                end
                // insert: empty, new head, or walk
                S_IN_START:
                begin
                    prev_reg <= head_reg;
                    iter_reg <= CNT_W'(1);
                    if (count_reg == '0)
                    begin
                        head_reg <= id_reg;
                        tail_reg <= id_reg;
                        mark_reg[id_reg] <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (prio_reg[head_reg] > prio_reg[id_reg])
                    begin
                        head_reg <= id_reg;
                        mark_reg[id_reg] <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_IN_RD;
                    end
                end
                S_IN_RD:
                begin
                    if (iter_reg >= count_reg || prev_reg == tail_reg)
                        state_reg <= S_IN_LINK;
                    else
                        state_reg <= S_IN_CHK;
                end
                S_IN_CHK:
                begin
                    if (prio_reg[rdata] > prio_reg[id_reg])
                    begin
                        state_reg <= S_IN_LINK;
                    end
                    else
                    begin
                        prev_reg  <= rdata;
                        iter_reg  <= iter_reg + 1'b1;
                        state_reg <= S_IN_RD;
                    end
                end
                // tail case links prev to id; otherwise id takes prev's successor first
                S_IN_LINK:
                begin
                    if (prev_reg == tail_reg)
                    begin
                        tail_reg <= id_reg;
                        mark_reg[id_reg] <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_IN_LINK2;
                    end
                end
                // link prev to id
                S_IN_LINK2:
                begin
                    mark_reg[id_reg] <= 1'b1;
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg)
                    begin
                        rsp_reg.out_task     <= otask_reg;
                        rsp_reg.out_priority <= ({1'b0, otask_reg} < 5'(NUM_TASKS)) ?
                                                3'(prio_reg[otask_reg]) : 3'd0;
                        rsp_reg.status       <= status_reg;
                        rsp_reg.queue_count  <= 5'(count_reg);
                        rsp_valid_reg        <= 1'b1;
                        state_reg            <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: verif/prq_scoreboard.sv
`timescale 1ns / 100ps

package prq_sb_pkg;
    import prq_pkg::*;

    class prq_scoreboard;
        logic [2:0] prio [NUM_TASKS];
        bit         marked [NUM_TASKS];
        logic [3:0] link [NUM_TASKS];
        logic [3:0] head;
        logic [3:0] tail;
        int         count;
        rsp_t       pending [$];
        int         errors;

        function new();
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                prio[i] = 3'(PRIO_LEVELS - 1);
                marked[i] = 0;
                link[i] = 0;
            end
            head = 0;
            tail = 0;
            count = 0;
            errors = 0;
        endfunction

        // unlink a task from the ordered list
        function void unlink(logic [3:0] id);
            logic [3:0] prev;
            logic [3:0] nxt;
            if (count == 0)
                return;
            if (head == id)
            begin
                if (count > 1)
                    head = link[head];
                count--;
                marked[id] = 0;
                return;
            end
            prev = head;
            for (int i = 1; i < count; i++)
            begin
                nxt = link[prev];
                if (nxt == id)
                begin
                    if (tail == id)
                        tail = prev;
                    else
                        link[prev] = link[id];
                    count--;
                    marked[id] = 0;
                    return;
                end
                prev = nxt;
            end
        endfunction

        // insert after every entry of equal or more urgent priority
        function void insert(logic [3:0] id);
            logic [2:0] p;
            logic [3:0] prev;
            logic [3:0] nxt;
            p = prio[id];
            if (count == 0)
            begin
                head = id;
                tail = id;
            end
            else if (prio[head] > p)
            begin
                link[id] = head;
                head = id;
            end
            else
            begin
                prev = head;
                for (int i = 1; i < count; i++)
                begin
                    if (prev == tail)
                        break;
                    nxt = link[prev];
                    if (prio[nxt] > p)
                        break;
                    prev = nxt;
                end
                if (prev == tail)
                    tail = id;
                else
                    link[id] = link[prev];
                link[prev] = id;
            end
            marked[id] = 1;
            count++;
        endfunction

        // note an accepted command and queue the response it predicts
        function void note_command(cmd_t c);
            rsp_t r;
            r.out_task = c.task_id;
            r.status = ST_OK;
            if (c.cmd == CMD_DEQ)
            begin
                if (count == 0)
                    r.status = ST_MISS;
                else
                begin
                    r.out_task = head;
                    unlink(head);
                end
            end
            else if (c.cmd == CMD_ENQ)
            begin
                if (marked[c.task_id])
                    r.status = ST_QUEUED;
                else
                    insert(c.task_id);
            end
            else if (c.cmd == CMD_REM)
            begin
                if (!marked[c.task_id])
                    r.status = ST_MISS;
                else
                    unlink(c.task_id);
            end
            else if (c.cmd == CMD_SET)
            begin
                if (marked[c.task_id])
                begin
                    unlink(c.task_id);
                    prio[c.task_id] = c.new_priority;
                    insert(c.task_id);
                end
                else
                    prio[c.task_id] = c.new_priority;
            end
            r.out_priority = prio[r.out_task];
            r.queue_count = 5'(count);
            pending.push_back(r);
        endfunction

        // compare one response with the oldest prediction
        function void check_response(rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected response %p", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.out_task !== want.out_task)
            begin
                $error("out_task expected %0d actual %0d", want.out_task, got.out_task);
                errors++;
            end
            if (got.out_priority !== want.out_priority)
            begin
                $error("out_priority expected %0d actual %0d",
                       want.out_priority, got.out_priority);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.queue_count !== want.queue_count)
            begin
                $error("queue_count expected %0d actual %0d",
                       want.queue_count, got.queue_count);
                errors++;
            end
        endfunction
    endclass
endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import prq_pkg::*;
    import prq_sb_pkg::*;

    logic clk;
    logic rst_n;
    prq_cmd_if cmd_ch ();
    prq_rsp_if rsp_ch ();
    prq_scoreboard sb;
    bit sending_done;

    priority_ready_queue_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // send one command transaction after a random gap
    task automatic send_command(logic [2:0] op, logic [3:0] id, logic [2:0] np);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.data.cmd <= op;
        cmd_ch.data.task_id <= id;
        cmd_ch.data.new_priority <= np;
        cmd_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sb.note_command('{cmd: op, task_id: id, new_priority: np});
        @(negedge clk);
    endtask

    // pick a random command, mostly well-formed scheduler traffic
    task automatic send_random();
        int r;
        logic [2:0] op;
        r = $urandom_range(0, 99);
        if (r < 35)
            op = CMD_ENQ;
        else if (r < 55)
            op = CMD_DEQ;
        else if (r < 70)
            op = CMD_REM;
        else if (r < 88)
            op = CMD_SET;
        else if (r < 96)
            op = CMD_GET;
        else
            op = 3'($urandom_range(5, 7));
        send_command(op, 4'($urandom), 3'($urandom));
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        sending_done = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // directed: empty cases, extremes, ties, reorder, unused codes
        send_command(CMD_DEQ, 4'd5, 3'd0);
        send_command(CMD_REM, 4'd3, 3'd0);
        send_command(CMD_GET, 4'd15, 3'd0);
        send_command(CMD_ENQ, 4'd0, 3'd0);
        send_command(CMD_ENQ, 4'd0, 3'd0);
        send_command(CMD_SET, 4'd15, 3'd0);
        send_command(CMD_ENQ, 4'd15, 3'd0);
        send_command(CMD_SET, 4'd7, 3'd3);
        send_command(CMD_ENQ, 4'd7, 3'd0);
        send_command(CMD_SET, 4'd8, 3'd3);
        send_command(CMD_ENQ, 4'd8, 3'd0);
        send_command(CMD_SET, 4'd0, 3'd0);
        send_command(CMD_SET, 4'd8, 3'd7);
        send_command(CMD_REM, 4'd7, 3'd0);
        send_command(CMD_GET, 4'd8, 3'd0);
        send_command(3'd5, 4'd8, 3'd7);
        send_command(3'd6, 4'd15, 3'd0);
        send_command(3'd7, 4'd0, 3'd5);
        for (int i = 0; i < 5; i++)
            send_command(CMD_DEQ, 4'd0, 3'd0);
        // random: weighted mix of all command codes
        for (int n = 0; n < 1700; n++)
            send_random();
        cmd_ch.valid <= 1'b0;
        sending_done = 1;
    end

    // response side with random stalls
    initial
    begin
        int gap;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            sb.check_response(rsp_ch.data);
        end
    end

    initial
    begin
        wait (sending_done);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
